// ===== sv/cialu_pkg.sv =====
package cialu_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADDX = 5'd1,
    OP_SUB  = 5'd2,
    OP_SUBX = 5'd3,
    OP_CMP  = 5'd4,
    OP_AND  = 5'd5,
    OP_OR   = 5'd6,
    OP_XOR  = 5'd7,
    OP_ASL  = 5'd8,
    OP_ASR  = 5'd9,
    OP_LSL  = 5'd10,
    OP_LSR  = 5'd11,
    OP_ROL  = 5'd12,
    OP_ROR  = 5'd13,
    OP_ROXL = 5'd14,
    OP_ROXR = 5'd15,
    OP_NOT  = 5'd16,
    OP_TEST = 5'd17,
    OP_BTST = 5'd18,
    OP_BCHG = 5'd19,
    OP_BCLR = 5'd20,
    OP_BSET = 5'd21
  } op_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_t;

  typedef enum logic [3:0] {
    CC_T  = 4'd0,
    CC_F  = 4'd1,
    CC_HI = 4'd2,
    CC_LS = 4'd3,
    CC_CC = 4'd4,
    CC_CS = 4'd5,
    CC_NE = 4'd6,
    CC_EQ = 4'd7,
    CC_VC = 4'd8,
    CC_VS = 4'd9,
    CC_PL = 4'd10,
    CC_MI = 4'd11,
    CC_GE = 4'd12,
    CC_LT = 4'd13,
    CC_GT = 4'd14,
    CC_LE = 4'd15
  } cond_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // bit4 x, bit3 n, bit2 z, bit1 v, bit0 c
  typedef struct packed {
    logic x;
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  // working value of the shifter between steps
  typedef struct packed {
    logic [31:0] res;
    logic        c;
    logic        v;
  } step_state_t;

  function automatic logic [31:0] size_mask(input logic [1:0] size);
    logic [31:0] m;
    case (size_t'(size))
      SZ_BYTE: m = 32'h0000_00ff;
      SZ_WORD: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] size_msb(input logic [1:0] size);
    logic [31:0] m;
    case (size_t'(size))
      SZ_BYTE: m = 32'h0000_0080;
      SZ_WORD: m = 32'h0000_8000;
      default: m = 32'h8000_0000;
    endcase
    return m;
  endfunction

  function automatic logic cond_eval(input logic [3:0] cc, input flags_t f);
    logic r;
    case (cond_t'(cc))
      CC_T:    r = 1'b1;
      CC_F:    r = 1'b0;
      CC_HI:   r = !f.c && !f.z;
      CC_LS:   r = f.c || f.z;
      CC_CC:   r = !f.c;
      CC_CS:   r = f.c;
      CC_NE:   r = !f.z;
      CC_EQ:   r = f.z;
      CC_VC:   r = !f.v;
      CC_VS:   r = f.v;
      CC_PL:   r = !f.n;
      CC_MI:   r = f.n;
      CC_GE:   r = f.n == f.v;
      CC_LT:   r = f.n != f.v;
      CC_GT:   r = (f.n == f.v) && !f.z;
      CC_LE:   r = (f.n != f.v) || f.z;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cialu_in_if.sv =====
interface cialu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic [1:0]  size;
  logic [31:0] src;
  logic [31:0] target;
  logic [5:0]  shift_count;
  logic [3:0]  condition;

  modport source (
    output valid, op, size, src, target, shift_count, condition,
    input  ready
  );
  modport sink (
    input  valid, op, size, src, target, shift_count, condition,
    output ready
  );
endinterface

// ===== sv/cialu_out_if.sv =====
interface cialu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic [4:0]  flags;
  logic        cond_true;

  modport source (
    output valid, result, flags, cond_true,
    input  ready
  );
  modport sink (
    input  valid, result, flags, cond_true,
    output ready
  );
endinterface

// ===== sv/cialu_alu.sv =====
module cialu_alu import cialu_pkg::*; (
  input  op_t         op,
  input  logic [1:0]  size,
  input  logic [31:0] src,
  input  logic [31:0] tgt,
  input  flags_t      fin,
  output logic [31:0] res,
  output flags_t      fout
);

  logic [31:0] mask;
  logic [31:0] msb;
  logic        is_sub;
  logic        ext;
  logic        cin;
  logic [32:0] addend;
  logic [32:0] sum;
  logic [31:0] sum_sz;
  logic        carry;
  logic [4:0]  idx_mask;
  logic [4:0]  idx;
  logic [31:0] bit_m;

  assign mask   = size_mask(size);
  assign msb    = size_msb(size);
  assign is_sub = (op == OP_SUB) || (op == OP_SUBX) || (op == OP_CMP);
  assign ext    = fin.x && ((op == OP_ADDX) || (op == OP_SUBX));
  // subtract as target plus inverted source plus one, less the extend bit
  assign addend = is_sub ? ~{1'b0, src} : {1'b0, src};
  assign cin    = is_sub ? !ext : ext;
  assign sum    = {1'b0, tgt} + addend + {32'd0, cin};
  assign sum_sz = sum[31:0] & mask;

  always_comb begin
    case (size_t'(size))
      SZ_BYTE: begin
        carry    = sum[8];
        idx_mask = 5'd7;
      end
      SZ_WORD: begin
        carry    = sum[16];
        idx_mask = 5'd15;
      end
      default: begin
        carry    = sum[32];
        idx_mask = 5'd31;
      end
    endcase
  end

  assign idx   = src[4:0] & idx_mask;
  assign bit_m = 32'd1 << idx;

  always_comb begin
    res  = tgt;
    fout = fin;
    case (op)
      OP_ADD, OP_ADDX: begin
        res    = sum_sz;
        fout.c = carry;
        fout.x = carry;
        fout.v = |(~(src ^ tgt) & (tgt ^ sum_sz) & msb);
        fout.n = |(sum_sz & msb);
        fout.z = (op == OP_ADD) ? (sum_sz == 32'd0) : (fin.z && (sum_sz == 32'd0));
      end
      OP_SUB, OP_SUBX, OP_CMP: begin
        res    = (op == OP_CMP) ? tgt : sum_sz;
        fout.c = carry;
        fout.x = (op == OP_CMP) ? fin.x : carry;
        fout.v = |((tgt ^ src) & (tgt ^ sum_sz) & msb);
        fout.n = |(sum_sz & msb);
        fout.z = (op == OP_SUBX) ? (fin.z && (sum_sz == 32'd0)) : (sum_sz == 32'd0);
      end
      OP_AND, OP_OR, OP_XOR, OP_NOT, OP_TEST: begin
        case (op)
          OP_AND:  res = tgt & src;
          OP_OR:   res = tgt | src;
          OP_XOR:  res = tgt ^ src;
          OP_NOT:  res = ~tgt & mask;
          default: res = tgt;
        endcase
        fout.c = 1'b0;
        fout.v = 1'b0;
        fout.n = |(res & msb);
        fout.z = (res == 32'd0);
      end
      OP_BTST, OP_BCHG, OP_BCLR, OP_BSET: begin
        fout.z = !(|(tgt & bit_m));
        case (op)
          OP_BCHG: res = (tgt ^ bit_m) & mask;
          OP_BCLR: res = tgt & ~bit_m;
          OP_BSET: res = (tgt | bit_m) & mask;
          default: res = tgt;
        endcase
      end
      default: begin
        res  = tgt;
        fout = fin;
      end
    endcase
  end

endmodule

// ===== sv/cialu_step.sv =====
module cialu_step import cialu_pkg::*; (
  input  op_t         op,
  input  logic [1:0]  size,
  input  step_state_t cur,
  output step_state_t nxt
);

  logic [31:0] mask;
  logic [31:0] msb;
  logic        top;
  logic        bot;
  logic [31:0] shl;
  logic [31:0] shr;

  assign mask = size_mask(size);
  assign msb  = size_msb(size);
  assign top  = |(cur.res & msb);
  assign bot  = cur.res[0];
  assign shl  = (cur.res << 1) & mask;
  assign shr  = cur.res >> 1;

  // one bit position per call
  always_comb begin
    nxt = cur;
    case (op)
      OP_ASL: begin
        nxt.c   = top;
        nxt.res = shl;
        nxt.v   = cur.v | (top ^ (|(shl & msb)));
      end
      OP_LSL: begin
        nxt.c   = top;
        nxt.res = shl;
      end
      OP_ASR: begin
        nxt.c   = bot;
        nxt.res = shr | (cur.res & msb);
      end
      OP_LSR: begin
        nxt.c   = bot;
        nxt.res = shr;
      end
      OP_ROL: begin
        nxt.c   = top;
        nxt.res = shl | {31'd0, top};
      end
      OP_ROR: begin
        nxt.c   = bot;
        nxt.res = shr | (bot ? msb : 32'd0);
      end
      OP_ROXL: begin
        nxt.c   = top;
        nxt.res = shl | {31'd0, cur.c};
      end
      OP_ROXR: begin
        nxt.c   = bot;
        nxt.res = shr | (cur.c ? msb : 32'd0);
      end
      default: nxt = cur;
    endcase
  end

endmodule

// ===== sv/cpu_integer_alu_with_flags_unit.sv =====
// integer alu with x n z v c flags, one operation per word. an accepted word
// is latched, shifts and rotates then run the shift_count steps through the
// one-bit shifter one after another (other operations take no steps), and a
// last step writes the result, the new flags and the condition truth into the
// output register once it is free; only then is the input ready for the next
// word, so one word is in flight at a time. the condition is judged on the
// flags as they stood when the word was accepted. the output register lets a
// finished result wait while the next word is taken. the flags reset to zero.
module cpu_integer_alu_with_flags_unit import cialu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cialu_in_if.sink  in_ch,
  cialu_out_if.source out_ch
);

  // sequencer
  state_t state;
  state_t state_next;

  // latched operation
  op_t         op_r;
  logic [1:0]  size_r;
  logic [31:0] src_r;
  logic [5:0]  cnt_r;
  logic        cnt_nz_r;
  logic        ct_r;
  step_state_t work;
  step_state_t work_next;

  // architectural flags
  flags_t flags;

  // output register
  logic        out_valid;
  logic [31:0] result_q;
  flags_t      flags_q;
  logic        ct_q;

  logic        accept;
  logic        is_shift;
  logic        step_en;
  logic        finish;
  logic [31:0] alu_res;
  flags_t      alu_flags;
  logic [31:0] fin_res;
  flags_t      fin_flags;
  logic [31:0] msb_r;
  logic [31:0] in_mask;
  op_t         in_op;

  assign in_op    = op_t'(in_ch.op);
  assign in_mask  = size_mask(in_ch.size);
  assign msb_r    = size_msb(size_r);
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_shift = (op_r == OP_ASL) || (op_r == OP_ASR) || (op_r == OP_LSL) ||
                    (op_r == OP_LSR) || (op_r == OP_ROL) || (op_r == OP_ROR) ||
                    (op_r == OP_ROXL) || (op_r == OP_ROXR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    step_en     = 1'b0;
    finish      = 1'b0;
    case (state)
      S_IDLE: in_ch.ready = 1'b1;
      S_EXEC: begin
        step_en = is_shift && (cnt_r != 6'd0);
        // wait for a free output register before retiring
        finish  = !step_en && (!out_valid || out_ch.ready);
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  cialu_step u_step (
    .op   (op_r),
    .size (size_r),
    .cur  (work),
    .nxt  (work_next)
  );

  cialu_alu u_alu (
    .op   (op_r),
    .size (size_r),
    .src  (src_r),
    .tgt  (work.res),
    .fin  (flags),
    .res  (alu_res),
    .fout (alu_flags)
  );

  // operand latch and shift iteration
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      size_r   <= in_ch.size;
      src_r    <= in_ch.src & in_mask;
      cnt_r    <= in_ch.shift_count;
      cnt_nz_r <= (in_ch.shift_count != 6'd0);
      ct_r     <= cond_eval(in_ch.condition, flags);
      work.res <= in_ch.target & in_mask;
      // extended rotates shift x in first
      work.c   <= ((in_op == OP_ROXL) || (in_op == OP_ROXR)) ? flags.x : 1'b0;
      work.v   <= 1'b0;
    end else if (step_en) begin
      work  <= work_next;
      cnt_r <= cnt_r - 6'd1;
    end
  end

  // retiring values
  always_comb begin
    fin_res   = alu_res;
    fin_flags = alu_flags;
    if (is_shift) begin
      fin_res     = work.res;
      fin_flags.n = |(work.res & msb_r);
      fin_flags.z = (work.res == 32'd0);
      fin_flags.v = work.v;
      fin_flags.c = work.c;
      case (op_r)
        OP_ROL, OP_ROR:   fin_flags.x = flags.x;
        OP_ROXL, OP_ROXR: fin_flags.x = work.c;
        default:          fin_flags.x = cnt_nz_r ? work.c : flags.x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        flags     <= fin_flags;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_q <= fin_res;
      flags_q  <= fin_flags;
      ct_q     <= ct_r;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.result    = result_q;
  assign out_ch.flags     = flags_q;
  assign out_ch.cond_true = ct_q;

  // a word in flight blocks the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ch.ready)
    else $error("input ready while a word is in flight");

  // the shown flags are the live flags
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flags_q == flags))
    else $error("output flags differ from flag register");

  // each shifter step consumes one count
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    step_en |=> (cnt_r == $past(cnt_r) - 6'd1))
    else $error("shift count did not step down");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !finish)
    else $error("result retired onto a stalled output");

endmodule
